// ===== rtl/core/sha1e_pkg.sv =====
// sha1e_pkg: shared types, constants and helpers for the sha-1 hash engine
`timescale 1ns / 1ps
package sha1e_pkg;

  // command handed from the front end to the compression back end
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       is_last;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_LEN,
    ST_OUT
  } state_t;

  localparam int unsigned ROUNDS   = 80;
  localparam int unsigned RND_W    = 7;
  localparam int unsigned FILL_W   = 6;
  localparam int unsigned WORDS    = 16;
  localparam int unsigned BLOCK_W  = 512;

  localparam logic [FILL_W-1:0] FILL_LAST = 6'd63;
  localparam logic [FILL_W-1:0] FILL_LEN  = 6'd55;
  localparam logic [RND_W-1:0]  RND_LAST  = 7'd79;
  localparam logic [RND_W-1:0]  RND_B1    = 7'd20;
  localparam logic [RND_W-1:0]  RND_B2    = 7'd40;
  localparam logic [RND_W-1:0]  RND_B3    = 7'd60;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

  function automatic logic [31:0] rotl5(input logic [31:0] x);
    rotl5 = {x[26:0], x[31:27]};
  endfunction

  function automatic logic [31:0] rotl30(input logic [31:0] x);
    rotl30 = {x[1:0], x[31:2]};
  endfunction

  function automatic logic [31:0] rotl1(input logic [31:0] x);
    rotl1 = {x[30:0], x[31]};
  endfunction

endpackage

// ===== rtl/core/sha1e_front.sv =====
// sha1e_front: input register that classifies items and drops empty ones that do not end a message
`timescale 1ns / 1ps
module sha1e_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               no_data,
  input  logic               is_last,
  output logic               push,
  output sha1e_pkg::cmd_t    push_cmd,
  input  logic               q_full
);

  logic            held;
  sha1e_pkg::cmd_t cmd;
  logic            accept;
  logic            useful;

  assign in_stall = held && q_full;
  assign accept   = in_valid && !in_stall;
  // an item with no byte that does not end the message changes nothing
  assign useful   = !no_data || is_last;
  assign push     = held && !q_full;
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= useful;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd.data     <= data_byte;
      cmd.has_byte <= !no_data;
      cmd.is_last  <= is_last;
    end
  end

endmodule

// ===== rtl/core/sha1e_queue.sv =====
// sha1e_queue: two-entry command queue between front and back end
`timescale 1ns / 1ps
module sha1e_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sha1e_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output sha1e_pkg::cmd_t q_cmd
);

  sha1e_pkg::cmd_t slot [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_cmd   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_cmd;
  end

endmodule

// ===== rtl/core/sha1e_back.sv =====
// sha1e_back: block buffer, padding sequencer and 80-round compression
`timescale 1ns / 1ps
module sha1e_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  sha1e_pkg::cmd_t q_cmd,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [31:0]     digest_h0,
  output logic [31:0]     digest_h1,
  output logic [31:0]     digest_h2,
  output logic [31:0]     digest_h3,
  output logic [31:0]     digest_h4,
  output logic            length_error
);

  sha1e_pkg::state_t state, state_next;

  logic [sha1e_pkg::BLOCK_W-1:0] w;
  logic [sha1e_pkg::FILL_W-1:0]  fill;
  logic [63:0]                   bitlen;
  logic                          ovf;
  logic [31:0]                   h0, h1, h2, h3, h4;
  logic [31:0]                   a, b, c, d, e;
  logic [sha1e_pkg::RND_W-1:0]   rnd;
  logic                          final_blk;
  logic                          len_done;
  logic                          pad_first;
  logic                          err;

  logic [63:0] bitlen_inc;
  logic        absorb;
  logic        ovf_now;
  logic        blk_full;
  logic [31:0] f, k, t, wnew;
  logic [31:0] w0, w2, w8, w13;

  assign bitlen_inc = bitlen + 64'd8;
  assign absorb     = q_valid && q_cmd.has_byte && !ovf;
  assign ovf_now    = ovf || (absorb && (bitlen_inc == 64'd0));
  assign blk_full   = absorb && (fill == sha1e_pkg::FILL_LAST);

  // window of the message schedule, oldest word at the top
  assign w0  = w[511:480];
  assign w2  = w[447:416];
  assign w8  = w[255:224];
  assign w13 = w[95:64];
  assign wnew = sha1e_pkg::rotl1(w13 ^ w8 ^ w2 ^ w0);

  always_comb begin
    if (rnd < sha1e_pkg::RND_B1) begin
      f = (b & c) | (~b & d);
      k = sha1e_pkg::K0;
    end else if (rnd < sha1e_pkg::RND_B2) begin
      f = b ^ c ^ d;
      k = sha1e_pkg::K1;
    end else if (rnd < sha1e_pkg::RND_B3) begin
      f = (b & c) | (b & d) | (c & d);
      k = sha1e_pkg::K2;
    end else begin
      f = b ^ c ^ d;
      k = sha1e_pkg::K3;
    end
  end

  assign t = sha1e_pkg::rotl5(a) + f + e + w0 + k;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sha1e_pkg::ST_IDLE: begin
        if (q_valid) begin
          if (blk_full)            state_next = sha1e_pkg::ST_ROUND;
          else if (q_cmd.is_last)  state_next = ovf_now ? sha1e_pkg::ST_OUT
                                                        : sha1e_pkg::ST_PAD;
        end
      end
      sha1e_pkg::ST_ROUND: begin
        if (rnd == sha1e_pkg::RND_LAST) state_next = sha1e_pkg::ST_ADD;
      end
      sha1e_pkg::ST_ADD: begin
        if (!final_blk)            state_next = sha1e_pkg::ST_IDLE;
        else if (ovf || len_done)  state_next = sha1e_pkg::ST_OUT;
        else                       state_next = sha1e_pkg::ST_PAD;
      end
      sha1e_pkg::ST_PAD: begin
        if (fill == sha1e_pkg::FILL_LAST)     state_next = sha1e_pkg::ST_ROUND;
        else if (fill == sha1e_pkg::FILL_LEN) state_next = sha1e_pkg::ST_LEN;
      end
      sha1e_pkg::ST_LEN: begin
        if (fill == sha1e_pkg::FILL_LAST) state_next = sha1e_pkg::ST_ROUND;
      end
      sha1e_pkg::ST_OUT: begin
        if (!out_stall) state_next = sha1e_pkg::ST_IDLE;
      end
      default: state_next = sha1e_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop          = (state == sha1e_pkg::ST_IDLE) && q_valid;
    out_valid    = (state == sha1e_pkg::ST_OUT);
    digest_h0    = err ? 32'd0 : h0;
    digest_h1    = err ? 32'd0 : h1;
    digest_h2    = err ? 32'd0 : h2;
    digest_h3    = err ? 32'd0 : h3;
    digest_h4    = err ? 32'd0 : h4;
    length_error = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sha1e_pkg::ST_IDLE;
      fill      <= '0;
      bitlen    <= '0;
      ovf       <= 1'b0;
      h0        <= sha1e_pkg::H0_INIT;
      h1        <= sha1e_pkg::H1_INIT;
      h2        <= sha1e_pkg::H2_INIT;
      h3        <= sha1e_pkg::H3_INIT;
      h4        <= sha1e_pkg::H4_INIT;
      rnd       <= '0;
      final_blk <= 1'b0;
      len_done  <= 1'b0;
      pad_first <= 1'b0;
      err       <= 1'b0;
    end else begin
      state <= state_next;
      if (state != sha1e_pkg::ST_ROUND && state_next == sha1e_pkg::ST_ROUND) begin
        rnd <= '0;
      end
      unique case (state)
        sha1e_pkg::ST_IDLE: begin
          if (q_valid) begin
            if (absorb) begin
              fill   <= fill + 6'd1;
              bitlen <= bitlen_inc;
            end
            ovf       <= ovf_now;
            err       <= ovf_now;
            final_blk <= q_cmd.is_last;
            pad_first <= 1'b1;
          end
        end
        sha1e_pkg::ST_ROUND: begin
          rnd <= rnd + 7'd1;
        end
        sha1e_pkg::ST_ADD: begin
          h0  <= h0 + a;
          h1  <= h1 + b;
          h2  <= h2 + c;
          h3  <= h3 + d;
          h4  <= h4 + e;
          err <= ovf;
        end
        sha1e_pkg::ST_PAD: begin
          fill      <= fill + 6'd1;
          pad_first <= 1'b0;
        end
        sha1e_pkg::ST_LEN: begin
          fill   <= fill + 6'd1;
          bitlen <= {bitlen[55:0], 8'h00};
          if (fill == sha1e_pkg::FILL_LAST) len_done <= 1'b1;
        end
        sha1e_pkg::ST_OUT: begin
          if (!out_stall) begin
            fill      <= '0;
            bitlen    <= '0;
            ovf       <= 1'b0;
            h0        <= sha1e_pkg::H0_INIT;
            h1        <= sha1e_pkg::H1_INIT;
            h2        <= sha1e_pkg::H2_INIT;
            h3        <= sha1e_pkg::H3_INIT;
            h4        <= sha1e_pkg::H4_INIT;
            final_blk <= 1'b0;
            len_done  <= 1'b0;
            err       <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // block buffer as a byte shift line and the working variables
  always_ff @(posedge clk) begin
    if (state != sha1e_pkg::ST_ROUND && state_next == sha1e_pkg::ST_ROUND) begin
      a <= h0;
      b <= h1;
      c <= h2;
      d <= h3;
      e <= h4;
    end else if (state == sha1e_pkg::ST_ROUND) begin
      a <= t;
      b <= a;
      c <= sha1e_pkg::rotl30(b);
      d <= c;
      e <= d;
    end
    case (state)
      sha1e_pkg::ST_IDLE: if (absorb) w <= {w[503:0], q_cmd.data};
      sha1e_pkg::ST_ROUND: w <= {w[479:0], wnew};
      sha1e_pkg::ST_PAD:
        w <= {w[503:0], pad_first ? sha1e_pkg::PAD_BYTE : sha1e_pkg::ZERO_BYTE};
      sha1e_pkg::ST_LEN: w <= {w[503:0], bitlen[63:56]};
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/sha1_hash_engine_unit.sv =====
// sha1_hash_engine_unit: top level of the byte-serial sha-1 hash engine
//
//  channel | beat                               | handshake
//  --------+------------------------------------+----------------------
//  in      | data_byte, no_data, is_last        | in_valid / in_stall
//  out     | digest_h0..digest_h4, length_error | out_valid / out_stall
//
// message bytes are absorbed one per cycle while the block is filling
// a full 64-byte block is compressed in 80 rounds followed by one add
// the last beat adds the 0x80 pad, zero bytes, the 8-byte length and one or
// two compressions before the digest appears, unless the length overflowed
// reset is synchronous; the engine restarts from the initial chain words
// the front register and a two-entry queue hold up to three beats while
// the back works, after which the input stalls
`timescale 1ns / 1ps
module sha1_hash_engine_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        no_data,
  input  logic        is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_h0,
  output logic [31:0] digest_h1,
  output logic [31:0] digest_h2,
  output logic [31:0] digest_h3,
  output logic [31:0] digest_h4,
  output logic        length_error
);

  // front to queue
  logic            push;
  sha1e_pkg::cmd_t push_cmd;
  logic            q_full;

  // queue to back
  logic            pop;
  logic            q_valid;
  sha1e_pkg::cmd_t q_cmd;

  // classification: items with no byte that do not end a message vanish here
  sha1e_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .no_data   (no_data),
    .is_last   (is_last),
    .push      (push),
    .push_cmd  (push_cmd),
    .q_full    (q_full)
  );

  sha1e_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  // back end owns the block, length counter and chain words (the result, zeros on error)
  sha1e_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .digest_h0    (digest_h0),
    .digest_h1    (digest_h1),
    .digest_h2    (digest_h2),
    .digest_h3    (digest_h3),
    .digest_h4    (digest_h4),
    .length_error (length_error)
  );

endmodule

// ===== dv/testbench.sv =====
// testbench: self-checking bench for the byte-serial sha-1 hash engine
`timescale 1ns / 1ps
module testbench;

  // digest record as the block presents it
  typedef struct {
    logic [31:0] h [5];
    logic        err;
  } digest_t;

  // scoreboard: tracks the running hash state and holds pending digests
  class digest_board;
    logic [7:0]  buf_q [64];
    int unsigned fill;
    logic [63:0] bits;
    logic [31:0] chain [5];
    bit          ovf;
    digest_t     pending [$];
    int          errors;
    int          matched;

    function new();
      errors = 0;
      matched = 0;
      restart();
    endfunction

    function void restart();
      fill = 0;
      bits = '0;
      ovf = 0;
      chain[0] = sha1e_pkg::H0_INIT; chain[1] = sha1e_pkg::H1_INIT;
      chain[2] = sha1e_pkg::H2_INIT; chain[3] = sha1e_pkg::H3_INIT;
      chain[4] = sha1e_pkg::H4_INIT;
    endfunction

    function void compress();
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++)
        w[i] = {buf_q[4*i], buf_q[4*i+1], buf_q[4*i+2], buf_q[4*i+3]};
      for (int i = 16; i < 80; i++) begin
        t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
        w[i] = {t[30:0], t[31]};
      end
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
      for (int i = 0; i < 80; i++) begin
        if (i < 20) begin
          f = (b & c) | (~b & d); k = sha1e_pkg::K0;
        end else if (i < 40) begin
          f = b ^ c ^ d; k = sha1e_pkg::K1;
        end else if (i < 60) begin
          f = (b & c) | (b & d) | (c & d); k = sha1e_pkg::K2;
        end else begin
          f = b ^ c ^ d; k = sha1e_pkg::K3;
        end
        t = {a[26:0], a[31:27]} + f + e + w[i] + k;
        e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
      fill = 0;
    endfunction

    // note an accepted input beat
    function void note_beat(logic [7:0] byte_v, logic nd, logic last);
      digest_t dg;
      int unsigned pos;
      if (!nd && !ovf) begin
        buf_q[fill] = byte_v;
        fill++;
        bits += 64'd8;
        if (bits == 0) ovf = 1;
        if (fill >= 64) compress();
      end
      if (!last) return;
      if (ovf) begin
        foreach (dg.h[j]) dg.h[j] = '0;
        dg.err = 1;
      end else begin
        pos = fill;
        buf_q[pos++] = sha1e_pkg::PAD_BYTE;
        if (pos > 56) begin
          while (pos < 64) buf_q[pos++] = sha1e_pkg::ZERO_BYTE;
          compress();
          pos = 0;
        end
        while (pos < 56) buf_q[pos++] = sha1e_pkg::ZERO_BYTE;
        for (int i = 0; i < 8; i++) buf_q[56+i] = bits[63-8*i -: 8];
        compress();
        foreach (dg.h[j]) dg.h[j] = chain[j];
        dg.err = 0;
      end
      pending.push_back(dg);
      restart();
    endfunction

    // compare a delivered digest with the oldest pending one
    function void check_digest(digest_t got);
      digest_t exp_d;
      if (pending.size() == 0) begin
        $error("digest with nothing pending");
        errors++;
        return;
      end
      exp_d = pending.pop_front();
      for (int j = 0; j < 5; j++)
        if (got.h[j] !== exp_d.h[j]) begin
          $error("digest_h%0d expected %h actual %h", j, exp_d.h[j], got.h[j]);
          errors++;
        end
      if (got.err !== exp_d.err) begin
        $error("length_error expected %b actual %b", exp_d.err, got.err);
        errors++;
      end
      matched++;
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        no_data;
  logic        is_last;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] digest_h0, digest_h1, digest_h2, digest_h3, digest_h4;
  logic        length_error;

  sha1_hash_engine_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .no_data(no_data), .is_last(is_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .digest_h0(digest_h0), .digest_h1(digest_h1), .digest_h2(digest_h2),
    .digest_h3(digest_h3), .digest_h4(digest_h4),
    .length_error(length_error)
  );

  digest_board board = new();

  int send_idle_pct;   // chance in a hundred that the sender idles a cycle
  int recv_stall_pct;  // chance in a hundred that the receiver stalls
  bit hold_recv;       // long receiver hold-off under way
  int beats;
  int quiet;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // input beats are scored at the edge that accepts them
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      board.note_beat(data_byte, no_data, is_last);
      beats++;
    end
  end

  // output side: score accepted digests, then choose the next stall
  always @(posedge clk) begin
    digest_t got;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.h[0] = digest_h0; got.h[1] = digest_h1; got.h[2] = digest_h2;
        got.h[3] = digest_h3; got.h[4] = digest_h4;
        got.err = length_error;
        board.check_digest(got);
      end
      out_stall <= hold_recv || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog: cycles with no beat accepted on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("status: fail");
      $finish;
    end
  end

  // drive one beat, idling at random before it, and wait for acceptance
  task automatic send_beat(logic [7:0] b, logic nd, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    no_data   <= nd;
    is_last   <= last;
    do @(posedge clk); while (in_stall);
  endtask

  // a full message of n random bytes, optionally with a trailing empty end mark
  task automatic send_message(int n);
    if (n == 0) begin
      send_beat(8'($urandom), 1'b1, 1'b1);
    end else if ($urandom_range(3) == 0) begin
      for (int i = 0; i < n; i++) send_beat(8'($urandom), 1'b0, 1'b0);
      send_beat(8'($urandom), 1'b1, 1'b1);
    end else begin
      for (int i = 0; i < n; i++) send_beat(8'($urandom), 1'b0, i == n - 1);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // random message lengths, weighted to the padding boundaries
  function automatic int pick_len();
    case ($urandom_range(5))
      0:       return $urandom_range(54, 57);
      1:       return $urandom_range(62, 66);
      2:       return $urandom_range(100, 140);
      default: return $urandom_range(0, 30);
    endcase
  endfunction

  task automatic random_phase(int idle, int stall, int target);
    int r;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    while (beats < target) begin
      r = $urandom_range(9);
      if (r == 0)      // stray empty beat between messages
        send_beat(8'($urandom), 1'b1, 1'b0);
      else if (r == 1) // empty beat that may also end an empty message
        send_beat(8'($urandom), 1'b1, 1'($urandom_range(1)));
      else
        send_message(pick_len());
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = '0;
    no_data = 1'b0;
    is_last = 1'b0;
    hold_recv = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    beats = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty message, single extreme bytes, padding edges
    send_beat(8'h00, 1'b1, 1'b1);
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'hff, 1'b0, 1'b1);
    send_beat(8'h61, 1'b0, 1'b0);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'h62, 1'b0, 1'b0);
    send_beat(8'h63, 1'b0, 1'b1);
    send_beat(8'h5a, 1'b1, 1'b1);
    drain();
    send_message(55);
    send_message(56);
    send_message(63);
    send_message(64);
    drain();

    // long receiver hold-off while the sender keeps offering several messages
    hold_recv = 1'b1;
    fork
      for (int m = 0; m < 6; m++) send_message(40);
      begin
        repeat (1500) @(posedge clk);
        hold_recv = 1'b0;
      end
    join
    drain();

    random_phase(0, 0, 400);
    drain();
    random_phase(82, 0, 750);
    random_phase(0, 82, 1100);
    random_phase(16, 16, 1450);

    drain();
    repeat (400) @(posedge clk);
    $display("covered %0d input beats and %0d digests, incl. empty messages,",
             beats, board.matched);
    $display("padding boundaries, stray end marks and long output stalls");
    if (board.errors == 0 && board.pending.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
